@@ src/dcf_pkg.sv @@
`default_nettype none
package dcf_pkg;

  // frame and field widths
  localparam int FRAME_BITS_DEF = 60;
  localparam int NOW_W          = 32;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int OUT_FRAME_W    = 60;
  localparam int OUT_COUNT_W    = 6;

  // register reset values, microseconds
  localparam logic [CFG_W-1:0] SECOND_GAP_MIN_RST = 24'd700000;
  localparam logic [CFG_W-1:0] SECOND_GAP_MAX_RST = 24'd1000000;
  localparam logic [CFG_W-1:0] MINUTE_GAP_MIN_RST = 24'd1700000;
  localparam logic [CFG_W-1:0] MINUTE_GAP_MAX_RST = 24'd2000000;
  localparam logic [CFG_W-1:0] ZERO_PULSE_MIN_RST = 24'd30000;
  localparam logic [CFG_W-1:0] ZERO_PULSE_MAX_RST = 24'd135000;
  localparam logic [CFG_W-1:0] ONE_PULSE_MIN_RST  = 24'd140000;
  localparam logic [CFG_W-1:0] ONE_PULSE_MAX_RST  = 24'd260000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECOND_GAP_MIN = 3'd0,
    CFG_SECOND_GAP_MAX = 3'd1,
    CFG_MINUTE_GAP_MIN = 3'd2,
    CFG_MINUTE_GAP_MAX = 3'd3,
    CFG_ZERO_PULSE_MIN = 3'd4,
    CFG_ZERO_PULSE_MAX = 3'd5,
    CFG_ONE_PULSE_MIN  = 3'd6,
    CFG_ONE_PULSE_MAX  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] second_gap_min;
    logic [CFG_W-1:0] second_gap_max;
    logic [CFG_W-1:0] minute_gap_min;
    logic [CFG_W-1:0] minute_gap_max;
    logic [CFG_W-1:0] zero_pulse_min;
    logic [CFG_W-1:0] zero_pulse_max;
    logic [CFG_W-1:0] one_pulse_min;
    logic [CFG_W-1:0] one_pulse_max;
  } cfg_regs_t;

  typedef struct packed {
    logic             level;
    logic [NOW_W-1:0] now_us;
  } sample_t;

endpackage
`default_nettype wire

@@ src/dcf_in_if.sv @@
`default_nettype none
interface dcf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       level;
  logic [dcf_pkg::NOW_W-1:0]  now_us;

  modport source (output valid, output level, output now_us, input ready);
  modport sink (input valid, input level, input now_us, output ready);
endinterface
`default_nettype wire

@@ src/dcf_out_if.sv @@
`default_nettype none
interface dcf_out_if;
  logic                            valid;
  logic                            ready;
  logic [dcf_pkg::OUT_FRAME_W-1:0] frame_bits;
  logic [dcf_pkg::OUT_COUNT_W-1:0] bit_count;

  modport source (output valid, output frame_bits, output bit_count, input ready);
  modport sink (input valid, input frame_bits, input bit_count, output ready);
endinterface
`default_nettype wire

@@ src/dcf_cfg_regs.sv @@
`default_nettype none
module dcf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcf_pkg::CFG_W-1:0]     cfg_wdata,
  output dcf_pkg::cfg_regs_t           cfg
);
  import dcf_pkg::*;

  cfg_regs_t regs_r;

  // window registers, written one at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.second_gap_min <= SECOND_GAP_MIN_RST;
      regs_r.second_gap_max <= SECOND_GAP_MAX_RST;
      regs_r.minute_gap_min <= MINUTE_GAP_MIN_RST;
      regs_r.minute_gap_max <= MINUTE_GAP_MAX_RST;
      regs_r.zero_pulse_min <= ZERO_PULSE_MIN_RST;
      regs_r.zero_pulse_max <= ZERO_PULSE_MAX_RST;
      regs_r.one_pulse_min  <= ONE_PULSE_MIN_RST;
      regs_r.one_pulse_max  <= ONE_PULSE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SECOND_GAP_MIN: regs_r.second_gap_min <= cfg_wdata;
        CFG_SECOND_GAP_MAX: regs_r.second_gap_max <= cfg_wdata;
        CFG_MINUTE_GAP_MIN: regs_r.minute_gap_min <= cfg_wdata;
        CFG_MINUTE_GAP_MAX: regs_r.minute_gap_max <= cfg_wdata;
        CFG_ZERO_PULSE_MIN: regs_r.zero_pulse_min <= cfg_wdata;
        CFG_ZERO_PULSE_MAX: regs_r.zero_pulse_max <= cfg_wdata;
        CFG_ONE_PULSE_MIN:  regs_r.one_pulse_min  <= cfg_wdata;
        CFG_ONE_PULSE_MAX:  regs_r.one_pulse_max  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = regs_r;

endmodule
`default_nettype wire

@@ src/dcf_in_stage.sv @@
`default_nettype none
module dcf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  dcf_in_if.sink            in_ch,
  input  logic              adv,
  output logic              smp_valid,
  output dcf_pkg::sample_t  smp
);
  import dcf_pkg::*;

  logic    valid_r;
  sample_t sample_r;
  logic    take;

  // the register empties whenever the core moves on
  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (take) begin
      sample_r.level  <= in_ch.level;
      sample_r.now_us <= in_ch.now_us;
    end
  end

  assign smp_valid = valid_r;
  assign smp       = sample_r;

endmodule
`default_nettype wire

@@ src/dcf_core.sv @@
`default_nettype none
module dcf_core #(
  parameter int FRAME_BITS = dcf_pkg::FRAME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dcf_pkg::cfg_regs_t cfg,
  input  logic               smp_valid,
  input  dcf_pkg::sample_t   smp,
  output logic               adv,
  dcf_out_if.source          out_ch
);
  import dcf_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BITS + 1);
  localparam int POS_W = $clog2(FRAME_BITS);

  logic                  prev_level_r, prev_level_nxt;
  logic [NOW_W-1:0]      edge_time_r, edge_time_nxt;
  logic [FRAME_BITS-1:0] bit_store_r, bit_store_nxt;
  logic [CNT_W-1:0]      bits_held_r, bits_held_nxt;

  logic                   out_valid_r;
  logic [OUT_FRAME_W-1:0] frame_r, frame_out;
  logic [OUT_COUNT_W-1:0] count_r;

  logic [NOW_W-1:0] delta;
  logic [CNT_W-1:0] held_base;
  logic [63:0]      store_ext;
  logic             fire, change, emit;
  logic             sec_ok, min_ok, zero_ok, one_ok;

  function automatic logic in_window(input logic [NOW_W-1:0] v,
                                     input logic [CFG_W-1:0] lo,
                                     input logic [CFG_W-1:0] hi);
    return (v >= NOW_W'(lo)) && (v <= NOW_W'(hi));
  endfunction

  // the result register frees up or is being taken
  assign adv  = !out_valid_r || out_ch.ready;
  assign fire = smp_valid && adv;

  // edge timing and window tests
  always_comb begin
    change    = smp.level != prev_level_r;
    delta     = smp.now_us - edge_time_r;
    sec_ok    = (delta > NOW_W'(cfg.second_gap_min)) && (delta <= NOW_W'(cfg.second_gap_max));
    min_ok    = in_window(delta, cfg.minute_gap_min, cfg.minute_gap_max);
    zero_ok   = in_window(delta, cfg.zero_pulse_min, cfg.zero_pulse_max);
    one_ok    = in_window(delta, cfg.one_pulse_min, cfg.one_pulse_max);
    held_base = (bits_held_r >= CNT_W'(FRAME_BITS)) ? '0 : bits_held_r;
  end

  // next state for one sample
  always_comb begin
    prev_level_nxt = prev_level_r;
    edge_time_nxt  = edge_time_r;
    bit_store_nxt  = bit_store_r;
    bits_held_nxt  = bits_held_r;
    emit           = 1'b0;
    if (fire && change) begin
      prev_level_nxt = smp.level;
      edge_time_nxt  = smp.now_us;
      if (smp.level) begin
        // rising edge: classify the low gap
        if (sec_ok) begin
          emit = 1'b0;
        end else if (min_ok) begin
          emit          = 1'b1;
          bits_held_nxt = '0;
        end else begin
          bits_held_nxt = '0;
        end
      end else begin
        // falling edge: classify the high pulse, zero window first
        if (zero_ok || one_ok) begin
          bit_store_nxt[held_base[POS_W-1:0]] = !zero_ok;
          bits_held_nxt = held_base + CNT_W'(1);
        end else begin
          bits_held_nxt = '0;
        end
      end
    end
  end

  // frame with bits at or above the count forced low
  always_comb begin
    store_ext = 64'(bit_store_r);
    for (int i = 0; i < OUT_FRAME_W; i++) begin
      frame_out[i] = store_ext[i] && (CNT_W'(i) < bits_held_r);
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      edge_time_r  <= '0;
      bit_store_r  <= '0;
      bits_held_r  <= '0;
    end else begin
      prev_level_r <= prev_level_nxt;
      edge_time_r  <= edge_time_nxt;
      bit_store_r  <= bit_store_nxt;
      bits_held_r  <= bits_held_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_r <= frame_out;
      count_r <= bits_held_r[OUT_COUNT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_bits = frame_r;
  assign out_ch.bit_count  = count_r;

`ifndef SYNTH
  // count never runs past a full frame
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_held_r <= CNT_W'(FRAME_BITS))
    else $error("bit count beyond frame length");

  // an emitted frame carries the count held at the marker
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && (count_r == $past(bits_held_r[OUT_COUNT_W-1:0])))
    else $error("emitted count mismatch");

  // the minute marker restarts the frame
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> bits_held_r == '0)
    else $error("count not cleared after minute marker");

  // a sample without a level change leaves the state alone
  a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !change) |=> $stable(bits_held_r) && $stable(edge_time_r)
                          && $stable(prev_level_r))
    else $error("state moved without an edge");
`endif

endmodule
`default_nettype wire

@@ src/dcf77_pulse_frame_decoder_top.sv @@
`default_nettype none
// Pulse-width frame decoder for a time-signal receiver. Each sample transfer carries
// the receiver level and a microsecond timestamp; on every level change the high
// pulse or low gap since the previous edge is timed and checked against the four
// configurable windows. Pulses append zero or one bits to the frame, and a minute
// marker gap sends out one result with the collected bits and their count. One
// sample is taken every cycle while the result side is ready; a result passes
// through the sample register and then the result register, with a single stage
// of subtract and compare between them.
module dcf77_pulse_frame_decoder_top #(
  parameter int FRAME_BITS = dcf_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dcf_in_if.sink                        in_ch,
  dcf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcf_pkg::CFG_W-1:0]     cfg_wdata
);
  import dcf_pkg::*;

  cfg_regs_t cfg;
  sample_t   smp;
  logic      smp_valid;
  logic      adv;

  // window registers
  dcf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sample register
  dcf_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .adv       (adv),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  // edge classification and result register
  dcf_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .smp_valid (smp_valid),
    .smp       (smp),
    .adv       (adv),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
  import dcf_pkg::*;

  localparam int RUN_LIMIT      = 2_000_000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int SHOWN_ERRORS   = 10;

  localparam cfg_regs_t DEFAULT_WINDOWS = '{
    SECOND_GAP_MIN_RST, SECOND_GAP_MAX_RST, MINUTE_GAP_MIN_RST, MINUTE_GAP_MAX_RST,
    ZERO_PULSE_MIN_RST, ZERO_PULSE_MAX_RST, ONE_PULSE_MIN_RST, ONE_PULSE_MAX_RST
  };
  // bit windows overlap part way, second window runs into the minute window
  localparam cfg_regs_t OVERLAP_WINDOWS = '{
    24'd700000, 24'd1900000, 24'd1700000, 24'd2000000,
    24'd30000, 24'd200000, 24'd100000, 24'd260000
  };
  localparam cfg_regs_t WIDE_WINDOWS = '{
    24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF
  };

  typedef struct packed {
    logic [OUT_FRAME_W-1:0] frame;
    logic [OUT_COUNT_W-1:0] count;
  } minute_frame_t;

  typedef struct packed {
    logic                   level;
    logic [NOW_W-1:0]       stamp;
    logic                   typed;
    logic [OUT_FRAME_W-1:0] frame;
    logic [OUT_COUNT_W-1:0] count;
  } probe_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  dcf_in_if  in_ch ();
  dcf_out_if out_ch ();

  dcf77_pulse_frame_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // decoder copy: windows and edge state
  logic [CFG_W-1:0]       win [8] = '{
    SECOND_GAP_MIN_RST, SECOND_GAP_MAX_RST, MINUTE_GAP_MIN_RST, MINUTE_GAP_MAX_RST,
    ZERO_PULSE_MIN_RST, ZERO_PULSE_MAX_RST, ONE_PULSE_MIN_RST, ONE_PULSE_MAX_RST
  };
  logic                   last_level = 1'b0;
  logic [NOW_W-1:0]       last_edge  = '0;
  logic [OUT_FRAME_W-1:0] bit_store  = '0;
  int unsigned            held       = 0;

  minute_frame_t frames_due [$];
  minute_frame_t row_expect;
  bit            row_typed     = 1'b0;
  bit            gaps_on       = 1'b1;
  bit            hold_off_req  = 1'b0;
  logic          line_level    = 1'b0;
  logic [NOW_W-1:0] clock_us   = '0;
  int            errors        = 0;
  int            samples_taken = 0;
  int            frames_checked = 0;
  int            edges_sent    = 0;
  int            settings_used = 1;

  // directed samples, absolute timestamps, default windows
  probe_t probe_rows [20] = '{
    '{1'b1, 32'd1800000,    1'b1, 60'h0, 6'd0},  // first edge after reset, minute gap
    '{1'b1, 32'd1900000,    1'b0, 60'h0, 6'd0},  // no level change
    '{1'b0, 32'd1830000,    1'b0, 60'h0, 6'd0},  // zero pulse at lower bound
    '{1'b1, 32'd2530000,    1'b0, 60'h0, 6'd0},  // gap on exclusive bound, clears
    '{1'b0, 32'd2790000,    1'b0, 60'h0, 6'd0},  // one pulse at upper bound
    '{1'b1, 32'd3790000,    1'b0, 60'h0, 6'd0},  // second gap at upper bound
    '{1'b0, 32'd3925000,    1'b0, 60'h0, 6'd0},  // zero pulse at upper bound
    '{1'b1, 32'd4625001,    1'b0, 60'h0, 6'd0},  // second gap just inside
    '{1'b0, 32'd4765001,    1'b0, 60'h0, 6'd0},  // one pulse at lower bound
    '{1'b1, 32'd6765001,    1'b1, 60'h5, 6'd3},  // minute gap at upper bound
    '{1'b0, 32'd6795000,    1'b0, 60'h0, 6'd0},  // pulse too short
    '{1'b1, 32'd8495000,    1'b1, 60'h0, 6'd0},  // minute gap at lower bound, empty
    '{1'b0, 32'd8755001,    1'b0, 60'h0, 6'd0},  // pulse too long
    '{1'b1, 32'd9755002,    1'b0, 60'h0, 6'd0},  // gap between windows
    '{1'b0, 32'd9892002,    1'b0, 60'h0, 6'd0},  // pulse between bit windows
    '{1'b1, 32'hFFFF_FFFF,  1'b0, 60'h0, 6'd0},  // top timestamp
    '{1'b0, 32'h0001_869F,  1'b0, 60'h0, 6'd0},  // zero pulse across the wrap
    '{1'b1, 32'h001C_FDDF,  1'b1, 60'h0, 6'd1},  // minute gap, one zero bit
    '{1'b0, 32'h0000_0000,  1'b0, 60'h0, 6'd0},  // backwards stamp, huge width
    '{1'b1, 32'h0000_0000,  1'b0, 60'h0, 6'd0}   // zero-width gap
  };

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("mismatch: %s", msg);
  endfunction

  // pulse and gap decoding, one call per sample transfer
  function automatic bit decode_sample(input logic lvl, input logic [NOW_W-1:0] stamp,
                                       output minute_frame_t frame_out);
    logic [NOW_W-1:0]       width;
    logic [OUT_FRAME_W-1:0] keep;
    frame_out = '0;
    if (lvl == last_level) return 1'b0;
    last_level = lvl;
    width      = stamp - last_edge;
    last_edge  = stamp;
    if (lvl) begin
      // low gap just ended
      if (width > win[CFG_SECOND_GAP_MIN] && width <= win[CFG_SECOND_GAP_MAX]) return 1'b0;
      if (width >= win[CFG_MINUTE_GAP_MIN] && width <= win[CFG_MINUTE_GAP_MAX]) begin
        keep = (held >= OUT_FRAME_W) ? '1 : ~({OUT_FRAME_W{1'b1}} << held);
        frame_out.frame = bit_store & keep;
        frame_out.count = OUT_COUNT_W'(held);
        held = 0;
        return 1'b1;
      end
      held = 0;
      return 1'b0;
    end
    // high pulse just ended, full frame starts over
    if (held >= FRAME_BITS_DEF) held = 0;
    if (width >= win[CFG_ZERO_PULSE_MIN] && width <= win[CFG_ZERO_PULSE_MAX]) begin
      bit_store[held] = 1'b0;
      held++;
    end else if (width >= win[CFG_ONE_PULSE_MIN] && width <= win[CFG_ONE_PULSE_MAX]) begin
      bit_store[held] = 1'b1;
      held++;
    end else begin
      held = 0;
    end
    return 1'b0;
  endfunction

  // value inside [lo, hi], often on a bound; anything when the window is empty
  function automatic logic [NOW_W-1:0] pick_in(input logic [NOW_W-1:0] lo,
                                               input logic [NOW_W-1:0] hi);
    if (lo > hi) return $urandom_range(0, 2 ** CFG_W - 1);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [NOW_W-1:0] wild_span();
    cfg_idx_t k;
    k = cfg_idx_t'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 2 ** CFG_W - 1);
      2:       return NOW_W'(win[k]) + $urandom_range(0, 2) - 1;
      default: return '0;
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 92) return $urandom_range(7, 20);
    return $urandom_range(55, 62);
  endfunction

  function automatic cfg_regs_t random_windows();
    cfg_regs_t c;
    c.zero_pulse_min = CFG_W'($urandom_range(0, 100000));
    c.zero_pulse_max = CFG_W'(c.zero_pulse_min + $urandom_range(0, 150000));
    c.one_pulse_min  = CFG_W'(c.zero_pulse_max + $urandom_range(1, 50000));
    c.one_pulse_max  = CFG_W'(c.one_pulse_min + $urandom_range(0, 200000));
    c.second_gap_min = CFG_W'($urandom_range(0, 900000));
    c.second_gap_max = CFG_W'(c.second_gap_min + $urandom_range(1, 600000));
    c.minute_gap_min = CFG_W'(c.second_gap_max + $urandom_range(1, 500000));
    c.minute_gap_max = CFG_W'(c.minute_gap_min + $urandom_range(0, 1000000));
    return c;
  endfunction

  // one sample transfer, called and returning at a falling edge
  task automatic send_sample(input logic lvl, input logic [NOW_W-1:0] stamp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.level  <= lvl;
    in_ch.now_us <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // level change after span microseconds, sometimes a stray same-level sample first
  task automatic emit_edge(input logic lvl, input logic [NOW_W-1:0] span,
                           input int corrupt_pct);
    if ($urandom_range(0, 9) == 0) send_sample(line_level, $urandom);
    if ($urandom_range(0, 99) < corrupt_pct) span = wild_span();
    clock_us += span;
    send_sample(lvl, clock_us);
    line_level = lvl;
    edges_sent++;
  endtask

  // pulse and gap pairs of a minute, closed by the minute marker
  task automatic send_frame(input int nbits, input int corrupt_pct);
    bit b;
    if (!line_level)
      emit_edge(1'b1, pick_in(win[CFG_MINUTE_GAP_MIN], win[CFG_MINUTE_GAP_MAX]), corrupt_pct);
    if (nbits == 0) begin
      // empty minute: stray pulse, then the marker
      emit_edge(1'b0, wild_span(), corrupt_pct);
      emit_edge(1'b1, pick_in(win[CFG_MINUTE_GAP_MIN], win[CFG_MINUTE_GAP_MAX]), corrupt_pct);
    end
    for (int i = 0; i < nbits; i++) begin
      b = 1'($urandom_range(0, 1));
      emit_edge(1'b0, b ? pick_in(win[CFG_ONE_PULSE_MIN], win[CFG_ONE_PULSE_MAX])
                        : pick_in(win[CFG_ZERO_PULSE_MIN], win[CFG_ZERO_PULSE_MAX]),
                corrupt_pct);
      if (i == nbits - 1)
        emit_edge(1'b1, pick_in(win[CFG_MINUTE_GAP_MIN], win[CFG_MINUTE_GAP_MAX]),
                  corrupt_pct);
      else
        emit_edge(1'b1, pick_in(NOW_W'(win[CFG_SECOND_GAP_MIN]) + 1, win[CFG_SECOND_GAP_MAX]),
                  corrupt_pct);
    end
  endtask

  task automatic run_frames(input int n);
    int stop;
    stop = edges_sent + n;
    while (edges_sent < stop) send_frame(pick_len(), 8);
  endtask

  // stop offering, drain outstanding frames, let the pipe settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all eight window registers, one per cycle
  task automatic load_windows(input cfg_regs_t c);
    logic [CFG_W-1:0] vals [8];
    cfg_idx_t         k;
    vals = '{c.second_gap_min, c.second_gap_max, c.minute_gap_min, c.minute_gap_max,
             c.zero_pulse_min, c.zero_pulse_max, c.one_pulse_min, c.one_pulse_max};
    for (int i = 0; i < 8; i++) begin
      k = cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= k;
      cfg_wdata <= vals[i];
      win[k] = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // sample transfers feed the decoder copy, frame transfers are compared
  always @(posedge clk) begin
    minute_frame_t due;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        samples_taken++;
        if (decode_sample(in_ch.level, in_ch.now_us, due))
          frames_due.push_back(row_typed ? row_expect : due);
      end
      if (out_ch.valid && out_ch.ready) begin
        frames_checked++;
        if (frames_due.size() == 0) begin
          flag_error($sformatf("unexpected frame bits=%h count=%0d",
                               out_ch.frame_bits, out_ch.bit_count));
        end else begin
          due = frames_due.pop_front();
          if (out_ch.frame_bits !== due.frame)
            flag_error($sformatf("frame_bits expected %h got %h", due.frame,
                                 out_ch.frame_bits));
          if (out_ch.bit_count !== due.count)
            flag_error($sformatf("bit_count expected %0d got %0d", due.count,
                                 out_ch.bit_count));
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.level  = 1'b0;
    in_ch.now_us = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SECOND_GAP_MIN;
    cfg_wdata    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed samples on reset windows
    foreach (probe_rows[r]) begin
      row_typed  = probe_rows[r].typed;
      row_expect = '{frame: probe_rows[r].frame, count: probe_rows[r].count};
      send_sample(probe_rows[r].level, probe_rows[r].stamp);
    end
    row_typed  = 1'b0;
    line_level = 1'b1;
    clock_us   = '0;

    // reset windows: full frames, then a long result stall with short minutes
    clock_us = $urandom;
    send_frame(2, 0);
    send_frame(FRAME_BITS_DEF, 0);
    send_frame(FRAME_BITS_DEF + 1, 0);
    hold_off_req = 1'b1;
    repeat (12) send_frame($urandom_range(0, 3), 0);
    run_frames(30);

    // ordered random windows
    repeat (2) begin
      quiesce();
      load_windows(random_windows());
      clock_us = $urandom;
      run_frames(60);
    end

    // extreme and overlapping windows
    quiesce();
    load_windows('0);
    run_frames(20);
    quiesce();
    load_windows('1);
    run_frames(20);
    quiesce();
    load_windows(OVERLAP_WINDOWS);
    run_frames(20);
    quiesce();
    load_windows(WIDE_WINDOWS);
    run_frames(20);

    // back to reset windows, no idling on either side
    gaps_on = 1'b0;
    quiesce();
    load_windows(DEFAULT_WINDOWS);
    clock_us = $urandom;
    run_frames(80);
    quiesce();

    $display("summary: %0d samples transferred, %0d edges sent in frames, %0d window sets",
             samples_taken, edges_sent, settings_used);
    $display("summary: %0d minute frames compared, %0d mismatches", frames_checked, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
